/* rtl/core/ptt_pkg.sv */
// Package for the periodic timer slot table: request and result types,
// opcodes, field widths and the control/report bundles between cells and sequencer.
// Depends on nothing.
`default_nettype none
package ptt_pkg;

  // Default number of timer slots in the table.
  localparam int unsigned NUM_SLOTS_DEF = 8;
  // Largest number of slots one service request reports.
  localparam int unsigned MAX_RES = 8;
  // Saturation value of a slot's pending count.
  localparam logic [7:0] PEND_MAX = 8'd255;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned PEND_W   = 8;
  localparam int unsigned ID_W     = 3;
  localparam int unsigned TIME_W   = 32;

  // Request opcodes.
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_ADD     = 2'd1;
  localparam logic [1:0] OP_SERVICE = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [PERIOD_W-1:0] period;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]   slot_id;
    logic              valid_res;
    logic [PEND_W-1:0] pending;
    logic [TIME_W-1:0] time_now;
    logic              last;
  } res_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                tick;
    logic                launch;
    logic                is_add;
    logic                is_svc;
    logic                stop;
    logic [PERIOD_W-1:0] period;
  } cmd_t;

  // Merged report of the cell that currently holds the token.
  typedef struct packed {
    logic              hit;
    logic [PEND_W-1:0] pend;
    logic              at_last;
  } rpt_t;

endpackage
`default_nettype wire

/* rtl/core/ptt_cell.sv */
// One timer slot of the table: period, countdown, pending count and active flag,
// plus the token stage that walks requests along the row. Depends on ptt_pkg.
`default_nettype none
module ptt_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ptt_pkg::cmd_t  cmd,
  input  wire logic           tok_in,
  output logic                tok,
  output logic                hit,
  output logic [ptt_pkg::PEND_W-1:0] pend
);

  logic                           active;
  logic [ptt_pkg::PERIOD_W-1:0]   period;
  logic [ptt_pkg::PERIOD_W-1:0]   countdown;
  logic [ptt_pkg::PEND_W-1:0]     pending;
  logic                           claim;
  logic                           serve;

  // This cell claims itself for an add, or is reported by a service, only
  // while it holds the token.
  assign claim = tok & cmd.is_add & ~active;
  assign serve = tok & cmd.is_svc & active & (pending != '0);
  assign hit   = claim | serve;
  assign pend  = serve ? pending : '0;

  // Slot state and token stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok       <= 1'b0;
      active    <= 1'b0;
      period    <= '0;
      countdown <= '0;
      pending   <= '0;
    end else begin
      tok <= tok_in;
      if (cmd.tick) begin
        if (countdown != '0) begin
          countdown <= countdown - 1'b1;
        end else begin
          countdown <= period;
          if (pending != ptt_pkg::PEND_MAX) begin
            pending <= pending + 1'b1;
          end
        end
      end else if (claim) begin
        active    <= 1'b1;
        period    <= cmd.period;
        countdown <= cmd.period;
        pending   <= '0;
      end else if (serve) begin
        pending <= '0;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ptt_seq.sv */
// Sequencer of the timer table: takes requests, drives the cell row, keeps the
// tick counter and registers each result. Depends on ptt_pkg.
`default_nettype none
module ptt_seq #(
  parameter int unsigned NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire ptt_pkg::req_t req,
  output logic               busy,
  output logic               done,
  output ptt_pkg::res_t      res,
  output ptt_pkg::cmd_t      cmd,
  input  wire ptt_pkg::rpt_t rpt
);

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(ptt_pkg::MAX_RES + 1);
  localparam logic [CNT_W-1:0] CNT_STOP = CNT_W'(ptt_pkg::MAX_RES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_FLUSH
  } state_t;

  state_t                          state;
  logic                            is_add;
  logic                            is_svc;
  logic [ptt_pkg::PERIOD_W-1:0]    period;
  logic [IDX_W-1:0]                pos;
  logic [CNT_W-1:0]                cnt;
  logic                            buf_valid;
  logic [ptt_pkg::ID_W-1:0]        buf_id;
  logic [ptt_pkg::PEND_W-1:0]      buf_pend;
  logic [ptt_pkg::TIME_W-1:0]      tick_time;
  logic                            accept;
  logic                            sweeping;
  logic [IDX_W+ptt_pkg::ID_W-1:0]  pos_ext;
  logic [ptt_pkg::ID_W-1:0]        cur_id;

  assign busy     = (state != S_IDLE);
  assign accept   = start & ~busy;
  assign sweeping = (state == S_SWEEP);
  assign pos_ext  = {{ptt_pkg::ID_W{1'b0}}, pos};
  assign cur_id   = pos_ext[ptt_pkg::ID_W-1:0];

  // Broadcast to the cells. The token is halted as soon as an add has found
  // its slot or a service has reached its result limit.
  always_comb begin
    cmd.tick   = accept & (req.opcode == ptt_pkg::OP_TICK);
    cmd.launch = accept & ((req.opcode == ptt_pkg::OP_ADD) |
                           (req.opcode == ptt_pkg::OP_SERVICE));
    cmd.is_add = sweeping & is_add;
    cmd.is_svc = sweeping & is_svc;
    cmd.stop   = sweeping & rpt.hit & (is_add | (cnt == CNT_STOP));
    cmd.period = period;
  end

  // Control state, tick counter and the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      is_add    <= 1'b0;
      is_svc    <= 1'b0;
      pos       <= '0;
      cnt       <= '0;
      buf_valid <= 1'b0;
      tick_time <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.opcode)
              ptt_pkg::OP_TICK: begin
                tick_time <= tick_time + 1'b1;
              end
              ptt_pkg::OP_READ: begin
                done <= 1'b1;
                res  <= '{slot_id: '0, valid_res: 1'b0, pending: '0,
                          time_now: tick_time, last: 1'b1};
              end
              default: begin
                state     <= S_SWEEP;
                is_add    <= (req.opcode == ptt_pkg::OP_ADD);
                is_svc    <= (req.opcode == ptt_pkg::OP_SERVICE);
                period    <= req.period;
                pos       <= '0;
                cnt       <= '0;
                buf_valid <= 1'b0;
              end
            endcase
          end
        end
        S_SWEEP: begin
          pos <= pos + 1'b1;
          if (is_add) begin
            if (rpt.hit) begin
              done  <= 1'b1;
              res   <= '{slot_id: cur_id, valid_res: 1'b1, pending: '0,
                         time_now: '0, last: 1'b1};
              state <= S_IDLE;
            end else if (rpt.at_last) begin
              state <= S_FLUSH;
            end
          end else begin
            // A service holds each found slot back one step so that the
            // final one can be marked last.
            if (rpt.hit) begin
              if (buf_valid) begin
                done <= 1'b1;
                res  <= '{slot_id: buf_id, valid_res: 1'b1, pending: buf_pend,
                          time_now: '0, last: 1'b0};
              end
              buf_valid <= 1'b1;
              buf_id    <= cur_id;
              buf_pend  <= rpt.pend;
              cnt       <= cnt + 1'b1;
            end
            if (rpt.at_last || (rpt.hit && (cnt == CNT_STOP))) begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (buf_valid) begin
            res <= '{slot_id: buf_id, valid_res: 1'b1, pending: buf_pend,
                     time_now: '0, last: 1'b1};
          end else begin
            res <= '{slot_id: '0, valid_res: 1'b0, pending: '0,
                     time_now: '0, last: 1'b1};
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/periodic_task_timer_table_unit.sv */
// Top level of the periodic timer slot table: the sequencer and a row of
// slot cells linked by a token. Depends on ptt_pkg, ptt_seq and ptt_cell.
//
//   Channel   Ports                  Handshake
//   request   start, busy, req       taken at a clock edge with start high, busy low
//   result    done, res              each result marked by a one-cycle done strobe
//
// A tick takes effect at the edge that takes it and gives no result; busy stays low.
// A read time gives its result in the next cycle; busy stays low.
// An add or a service walks a token along the cell row, one slot per cycle, and busy
// is high until its last result. A service gives one result per slot found, at most
// eight, the last one flagged, or a single result with valid_res low if it finds none.
// Reset clears every slot and the tick counter; results cannot stall.
`default_nettype none
module periodic_task_timer_table_unit #(
  parameter int unsigned NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire ptt_pkg::req_t req,
  output logic               busy,
  output logic               done,
  output ptt_pkg::res_t      res
);

  ptt_pkg::cmd_t                     cmd;
  ptt_pkg::rpt_t                     rpt;
  logic [NUM_SLOTS-1:0]              tok;
  logic [NUM_SLOTS-1:0]              tok_in;
  logic [NUM_SLOTS-1:0]              hit;
  logic [ptt_pkg::PEND_W-1:0]        pend [NUM_SLOTS];

  ptt_seq #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .res   (res),
    .cmd   (cmd),
    .rpt   (rpt)
  );

  // The token enters the first cell on launch and moves one cell per cycle
  // until the sequencer halts it.
  genvar g;
  generate
    for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign tok_in[g] = cmd.launch;
      end else begin : g_link
        assign tok_in[g] = tok[g-1] & ~cmd.stop;
      end
      ptt_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .cmd    (cmd),
        .tok_in (tok_in[g]),
        .tok    (tok[g]),
        .hit    (hit[g]),
        .pend   (pend[g])
      );
    end
  endgenerate

  // Only the token holder drives its report, so the reports merge by OR.
  always_comb begin
    rpt.hit     = |hit;
    rpt.pend    = '0;
    rpt.at_last = tok[NUM_SLOTS-1];
    for (int i = 0; i < NUM_SLOTS; i++) begin
      rpt.pend = rpt.pend | pend[i];
    end
  end

endmodule
`default_nettype wire
